[hdl/sfc_pkg.sv]
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int W_NEAR    = 2;
  localparam int W_CENTRE  = 84;
  localparam int W_DIVISOR = 100;

  localparam int FW_BITS       = 11;
  localparam int FH_BITS       = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;

  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_HEIGHT = 1024;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // control word of an item entering the window stage
  typedef struct packed {
    logic emit;     // item releases a result
    logic at_edge;  // centre in last column: right column duplicated
    logic shift;    // new column enters the window
    logic bot_px;   // bottom tap of new column is the incoming pixel
    logic top_sel;  // line buffer holding the upper row
    logic clamp_t;
    logic clamp_b;
    logic clamp_l;
    logic last;
    logic clr;      // frame done, window cleared afterwards
  } s1_ctl_t;

  typedef struct packed {
    logic we0;
    logic we1;
    logic re;
  } ram_en_t;

endpackage

[hdl/clamped_3x3_smoothing_filter.sv]
`timescale 1ns / 1ps

// Channel  Signals                               Carries
// s_axis   tvalid tready tdata tuser             pixel (tdata), action (tuser)
// m_axis   tvalid tready tdata tlast             filtered (tdata), frame_last (tlast)
// cfg      cfg_we_i cfg_idx_i cfg_data_i         0 frame_width, 1 frame_height
//
// One transfer per cycle on either side while back-pressure does not hold it.
// Line buffers: two single-port-read RAMs, one read and one write per pixel; drain items do not write.
// A result, after the transfer that releases it, passes through the line read,
// window sum, magnitude, reciprocal multiply and output register stages.
// Stalls back up stage by stage; bubbles are absorbed before tready drops.
// No clearing pass after reset; a register write restarts the frame.

module clamped_3x3_smoothing_filter #(
  parameter int MAX_WIDTH  = sfc_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = sfc_pkg::DEF_PIXEL_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sfc_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [sfc_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // pixel
  input  logic                                  s_axis_tuser,  // action
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((PIXEL_BITS + 7) / 8) * 8-1:0] m_axis_tdata,  // filtered
  output logic                                  m_axis_tlast
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DB = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int TW = PIXEL_BITS + 7;

  sfc_pkg::ram_en_t      ram_en;
  logic [AW-1:0]         ram_addr;
  logic [PIXEL_BITS-1:0] ram_wdata, rd0, rd1, px1, filt;
  logic                  v1, win_ready, v2, last2, div_ready;
  sfc_pkg::s1_ctl_t      ctl1;
  logic [TW-1:0]         total2;

  sfc_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_action_i  (s_axis_tuser),
    .s_pixel_i   (s_axis_tdata[PIXEL_BITS-1:0]),
    .dn_ready_i  (win_ready),
    .ram_en_o    (ram_en),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .v1_o        (v1),
    .ctl_o       (ctl1),
    .px_o        (px1)
  );

  sfc_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_ram0 (
    .clk_i   (clk_i),
    .we_i    (ram_en.we0),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_en.re),
    .raddr_i (ram_addr),
    .rdata_o (rd0)
  );

  sfc_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_ram1 (
    .clk_i   (clk_i),
    .we_i    (ram_en.we1),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_en.re),
    .raddr_i (ram_addr),
    .rdata_o (rd1)
  );

  sfc_win #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_win (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cfg_we_i),
    .v1_i       (v1),
    .ctl_i      (ctl1),
    .px_i       (px1),
    .rd0_i      (rd0),
    .rd1_i      (rd1),
    .dn_ready_i (div_ready),
    .ready_o    (win_ready),
    .v2_o       (v2),
    .total_o    (total2),
    .last_o     (last2)
  );

  sfc_div #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .v_i       (v2),
    .total_i   (total2),
    .last_i    (last2),
    .ready_o   (div_ready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (filt),
    .m_last_o  (m_axis_tlast),
    .m_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = DB'(filt);

endmodule

[hdl/sfc_ram.sv]
`timescale 1ns / 1ps

module sfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/sfc_ctrl.sv]
`timescale 1ns / 1ps

module sfc_ctrl #(
  parameter int MAX_WIDTH  = sfc_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = sfc_pkg::DEF_PIXEL_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sfc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [sfc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               s_valid_i,
  output logic                               s_ready_o,
  input  logic                               s_action_i,
  input  logic [PIXEL_BITS-1:0]              s_pixel_i,
  input  logic                               dn_ready_i,
  output sfc_pkg::ram_en_t                   ram_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       ram_addr_o,
  output logic [PIXEL_BITS-1:0]              ram_wdata_o,
  output logic                               v1_o,
  output sfc_pkg::s1_ctl_t                   ctl_o,
  output logic [PIXEL_BITS-1:0]              px_o
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = $clog2(MAX_WIDTH + 2);
  localparam int FW = sfc_pkg::FW_BITS;
  localparam int FH = sfc_pkg::FH_BITS;

  logic [FW-1:0] fw_q, fw_d;
  logic [FH-1:0] fh_q, fh_d;
  logic [CW-1:0] ic_q, ic_d, oc_q, oc_d;
  logic [FH-1:0] ir_q, ir_d, or_q, or_d;
  logic [PW-1:0] pend_q, pend_d;
  logic          v1_q, v1_d;
  sfc_pkg::s1_ctl_t ctl_q, ctl_d;
  logic [PIXEL_BITS-1:0] px_q;

  logic [CW-1:0] eff_w;
  logic [FH-1:0] eff_h;
  logic [CW-1:0] ic_inc, oc_inc;
  logic          act, pend, do_any, restart;
  sfc_pkg::ram_en_t ram_en;

  always_comb begin
    if (fw_q < FW'(2)) begin
      eff_w = CW'(2);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(fw_q);
    end
    eff_h = (fh_q < FH'(2)) ? FH'(2) : fh_q;
  end

  assign s_ready_o = !v1_q || dn_ready_i;
  assign act       = s_valid_i && s_ready_o;
  assign pend      = (pend_q != '0);
  assign ic_inc    = ic_q + CW'(1);
  assign oc_inc    = oc_q + CW'(1);

  always_comb begin
    fw_d    = fw_q;
    fh_d    = fh_q;
    ic_d    = ic_q;
    ir_d    = ir_q;
    oc_d    = oc_q;
    or_d    = or_q;
    pend_d  = pend_q;
    ctl_d   = '0;
    ram_en  = '0;
    do_any  = 1'b0;
    restart = 1'b0;
    if (cfg_we_i) begin
      case (sfc_pkg::cfg_reg_e'(cfg_idx_i))
        sfc_pkg::CFG_FRAME_WIDTH:  fw_d = cfg_data_i[FW-1:0];
        sfc_pkg::CFG_FRAME_HEIGHT: fh_d = cfg_data_i[FH-1:0];
        default: ;
      endcase
      restart = 1'b1;
    end else if (act) begin
      if (!pend) begin
        if (!s_action_i) begin
          do_any         = 1'b1;
          ram_en.we0     = !ir_q[0];
          ram_en.we1     = ir_q[0];
          ram_en.re      = 1'b1;
          ctl_d.shift    = 1'b1;
          ctl_d.bot_px   = 1'b1;
          ctl_d.top_sel  = ir_q[0];
          ctl_d.at_edge  = (ic_q == '0);
          ctl_d.emit     = (ic_q == '0) ? (ir_q >= FH'(2)) : (ir_q >= FH'(1));
          if (ic_inc >= eff_w) begin
            ic_d = '0;
            ir_d = ir_q + FH'(1);
            if (ir_q + FH'(1) >= eff_h) begin
              pend_d = PW'(eff_w) + PW'(1);
            end
          end else begin
            ic_d = ic_inc;
          end
        end
      end else begin
        // drain: a virtual row below the frame
        do_any        = 1'b1;
        ctl_d.emit    = 1'b1;
        ctl_d.at_edge = (ic_q == '0) || (ic_q >= eff_w);
        ctl_d.shift   = (ic_q < eff_w);
        ctl_d.top_sel = ir_q[0];
        ram_en.re     = (ic_q < eff_w);
        ic_d          = ic_inc;
        pend_d        = pend_q - PW'(1);
        if (pend_q == PW'(1)) begin
          restart   = 1'b1;
          ctl_d.clr = 1'b1;
        end
      end
      if (ctl_d.emit) begin
        ctl_d.clamp_t = (or_q == '0);
        ctl_d.clamp_b = (or_q >= eff_h - FH'(1));
        ctl_d.clamp_l = (oc_q == '0);
        ctl_d.last    = (or_q >= eff_h - FH'(1)) && (oc_q >= eff_w - CW'(1));
        if (oc_inc >= eff_w) begin
          oc_d = '0;
          or_d = or_q + FH'(1);
        end else begin
          oc_d = oc_inc;
        end
      end
    end
    if (restart) begin
      ic_d   = '0;
      ir_d   = '0;
      oc_d   = '0;
      or_d   = '0;
      pend_d = '0;
    end
  end

  assign v1_d = act ? do_any : (v1_q && !dn_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FW'(sfc_pkg::RESET_WIDTH);
      fh_q   <= FH'(sfc_pkg::RESET_HEIGHT);
      ic_q   <= '0;
      ir_q   <= '0;
      oc_q   <= '0;
      or_q   <= '0;
      pend_q <= '0;
      v1_q   <= 1'b0;
    end else begin
      fw_q   <= fw_d;
      fh_q   <= fh_d;
      ic_q   <= ic_d;
      ir_q   <= ir_d;
      oc_q   <= oc_d;
      or_q   <= or_d;
      pend_q <= pend_d;
      v1_q   <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act) begin
      ctl_q <= ctl_d;
      px_q  <= s_pixel_i;
    end
  end

  assign ram_en_o    = ram_en;
  assign ram_addr_o  = ic_q[AW-1:0];
  assign ram_wdata_o = s_pixel_i;
  assign v1_o        = v1_q;
  assign ctl_o       = ctl_q;
  assign px_o        = px_q;

  a_pend_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != '0 |-> ir_q == eff_h)
    else $error("drain pending outside the row below the frame");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ic_q <= eff_w)
    else $error("input column beyond frame width");

  a_out_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    or_q < eff_h)
    else $error("output row beyond frame height");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !dn_ready_i |=> v1_q && $stable(ctl_q))
    else $error("window stage item lost under stall");

endmodule

[hdl/sfc_win.sv]
`timescale 1ns / 1ps

module sfc_win #(
  parameter int PIXEL_BITS = sfc_pkg::DEF_PIXEL_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clr_i,
  input  logic                    v1_i,
  input  sfc_pkg::s1_ctl_t        ctl_i,
  input  logic [PIXEL_BITS-1:0]   px_i,
  input  logic [PIXEL_BITS-1:0]   rd0_i,
  input  logic [PIXEL_BITS-1:0]   rd1_i,
  input  logic                    dn_ready_i,
  output logic                    ready_o,
  output logic                    v2_o,
  output logic [PIXEL_BITS+6:0]   total_o,
  output logic                    last_o
);

  localparam int TW = PIXEL_BITS + 7;

  logic [PIXEL_BITS-1:0] win_q [3][3];
  logic [PIXEL_BITS-1:0] win_d [3][3];
  logic [PIXEL_BITS-1:0] col_n [3];
  logic [PIXEL_BITS-1:0] tap   [3][3];
  logic [TW-1:0]         ext   [3][3];
  logic [1:0]            rt, rb, cl;
  logic [TW-1:0]         nsum, total_d, total_q;
  logic                  v2_q, last_q, leave;

  assign ready_o = !v2_q || dn_ready_i;
  assign leave   = v1_i && ready_o;

  always_comb begin
    col_n[0] = ctl_i.top_sel ? rd1_i : rd0_i;
    col_n[1] = ctl_i.top_sel ? rd0_i : rd1_i;
    col_n[2] = ctl_i.bot_px ? px_i : col_n[1];
    for (int r = 0; r < 3; r++) begin
      tap[r][0] = win_q[r][1];
      tap[r][1] = win_q[r][2];
      tap[r][2] = ctl_i.at_edge ? win_q[r][2] : col_n[r];
      for (int c = 0; c < 3; c++) begin
        ext[r][c] = {{(TW-PIXEL_BITS){tap[r][c][PIXEL_BITS-1]}}, tap[r][c]};
      end
    end
    rt = ctl_i.clamp_t ? 2'd1 : 2'd0;
    rb = ctl_i.clamp_b ? 2'd1 : 2'd2;
    cl = ctl_i.clamp_l ? 2'd1 : 2'd0;
    nsum = ext[rt][cl] + ext[rt][1] + ext[rt][2] + ext[1][cl] + ext[1][2]
         + ext[rb][cl] + ext[rb][1] + ext[rb][2];
    total_d = nsum * TW'(sfc_pkg::W_NEAR) + ext[1][1] * TW'(sfc_pkg::W_CENTRE);
  end

  always_comb begin
    win_d = win_q;
    if (leave && ctl_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r][0] = win_q[r][1];
        win_d[r][1] = win_q[r][2];
        win_d[r][2] = col_n[r];
      end
    end
    if ((leave && ctl_i.clr) || clr_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_d[r][c] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      win_q <= win_d;
      if (ready_o) begin
        v2_q <= v1_i && ctl_i.emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      total_q <= total_d;
      last_q  <= ctl_i.last;
    end
  end

  assign v2_o    = v2_q;
  assign total_o = total_q;
  assign last_o  = last_q;

endmodule

[hdl/sfc_div.sv]
`timescale 1ns / 1ps

module sfc_div #(
  parameter int PIXEL_BITS = sfc_pkg::DEF_PIXEL_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  v_i,
  input  logic [PIXEL_BITS+6:0] total_i,
  input  logic                  last_i,
  output logic                  ready_o,
  output logic                  m_valid_o,
  output logic [PIXEL_BITS-1:0] m_data_o,
  output logic                  m_last_o,
  input  logic                  m_ready_i
);

  localparam int TW = PIXEL_BITS + 7;
  localparam int NB = PIXEL_BITS + 6;
  localparam int SH = NB + 7;
  localparam int MB = NB + 1;
  localparam int PB = NB + MB;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(sfc_pkg::W_DIVISOR - 1)) / 64'(sfc_pkg::W_DIVISOR);
  localparam logic [MB-1:0] RECIP_M = MB'(RECIP);

  logic                  va_q, vb_q, vc_q;
  logic                  ra, rb, rc;
  logic                  neg_a_q, neg_b_q, last_a_q, last_b_q, last_c_q;
  logic [NB-1:0]         mag_q;
  logic [TW-1:0]         abs_d;
  logic [PB-1:0]         prod_q;
  logic [PIXEL_BITS-1:0] quo, res_d, res_q;

  assign rc      = !vc_q || m_ready_i;
  assign rb      = !vb_q || rc;
  assign ra      = !va_q || rb;
  assign ready_o = ra;

  assign abs_d = total_i[TW-1] ? (~total_i + TW'(1)) : total_i;
  assign quo   = prod_q[SH +: PIXEL_BITS];
  assign res_d = neg_b_q ? (~quo + PIXEL_BITS'(1)) : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ra) begin
        va_q <= v_i;
      end
      if (rb) begin
        vb_q <= va_q;
      end
      if (rc) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ra) begin
      mag_q    <= abs_d[NB-1:0];
      neg_a_q  <= total_i[TW-1];
      last_a_q <= last_i;
    end
    if (rb) begin
      prod_q   <= PB'(mag_q) * PB'(RECIP_M);
      neg_b_q  <= neg_a_q;
      last_b_q <= last_a_q;
    end
    if (rc) begin
      res_q    <= res_d;
      last_c_q <= last_b_q;
    end
  end

  assign m_valid_o = vc_q;
  assign m_data_o  = res_q;
  assign m_last_o  = last_c_q;

endmodule

[bench/tb_clamped_3x3_smoothing_filter.sv]
`timescale 1ns / 1ps

module tb_clamped_3x3_smoothing_filter;

  localparam int MAX_W       = 1024;
  localparam int PIX_BITS    = 16;
  localparam int NEAR_WT     = 2;
  localparam int CENTRE_WT   = 84;
  localparam int DIVISOR     = 100;
  localparam int SETTLE_CYC  = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int CFG_IW      = sfc_pkg::CFG_IDX_BITS;
  localparam int CFG_DW      = sfc_pkg::CFG_DATA_BITS;
  localparam int FW_W        = sfc_pkg::FW_BITS;
  localparam int FH_W        = sfc_pkg::FH_BITS;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef logic signed [PIX_BITS-1:0] pix_t;

  typedef struct packed {
    logic action;
    pix_t pixel;
  } px_item_t;

  typedef struct {
    pix_t filtered;
    logic frame_last;
  } smooth_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IW-1:0]    cfg_idx_i = '0;
  logic [CFG_DW-1:0]    cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PIX_BITS-1:0]  s_axis_tdata = '0;   // [15:0] pixel
  logic                 s_axis_tuser = 1'b0; // [0] action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [PIX_BITS-1:0]  m_axis_tdata;        // [15:0] filtered
  logic                 m_axis_tlast;

  clamped_3x3_smoothing_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // stimulus and expectations
  px_item_t    pend_items[$];
  smooth_res_t smooth_exp_q[$];
  int          send_idle_pct = 20;
  int          recv_idle_pct = 84;
  int          mismatches = 0;
  int          cycles = 0;
  int          items_queued = 0;
  logic        in_fire = 1'b0;

  // filter model state
  logic [FW_W-1:0] width_reg = 11'd1024;
  logic [FH_W-1:0] height_reg = 16'd1024;
  pix_t        line_mem [0:2*MAX_W-1];
  pix_t        win [0:2][0:2];
  int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0, pend_cnt = 0;

  function automatic int unsigned eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < 2) ? 2 : height_reg;
  endfunction

  function automatic int unsigned line_addr(int unsigned parity, int unsigned col);
    return ((parity & 1) * MAX_W + col % MAX_W) % (2 * MAX_W);
  endfunction

  function automatic void clear_frame();
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    end
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    pend_cnt = 0;
  endfunction

  function automatic void push_column(pix_t top, pix_t mid, pix_t bot);
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
  endfunction

  // right column duplicated when the centre sits in the last column
  function automatic int win_tap(int r, int c, bit dup_right);
    if (dup_right) return (c == 0) ? int'(win[r][1]) : int'(win[r][2]);
    return int'(win[r][c]);
  endfunction

  function automatic void emit_pixel(bit dup_right);
    int unsigned wd, ht;
    int t, b, l, nsum, total;
    smooth_res_t res;
    wd = eff_width();
    ht = eff_height();
    t = (out_row == 0) ? 1 : 0;
    b = (out_row >= ht - 1) ? 1 : 2;
    l = (out_col == 0) ? 1 : 0;
    nsum = win_tap(t, l, dup_right) + win_tap(t, 1, dup_right) + win_tap(t, 2, dup_right) +
           win_tap(1, l, dup_right) + win_tap(1, 2, dup_right) +
           win_tap(b, l, dup_right) + win_tap(b, 1, dup_right) + win_tap(b, 2, dup_right);
    total = NEAR_WT * nsum + CENTRE_WT * win_tap(1, 1, dup_right);
    res.filtered = pix_t'(total / DIVISOR);
    res.frame_last = (out_row >= ht - 1) && (out_col >= wd - 1);
    smooth_exp_q.push_back(res);
    out_col++;
    if (out_col >= wd) begin
      out_col = 0;
      out_row++;
    end
  endfunction

  function automatic void smooth_predict(logic action, pix_t px);
    int unsigned wd, ht, ic, ir;
    pix_t top, mid;
    wd = eff_width();
    ht = eff_height();
    ic = in_col;
    ir = in_row;
    if (pend_cnt == 0) begin
      if (action == ACT_DRAIN) return;
      top = line_mem[line_addr(ir, ic)];
      mid = line_mem[line_addr(ir + 1, ic)];
      line_mem[line_addr(ir, ic)] = px;
      if (ic == 0) begin
        if (ir >= 2) emit_pixel(1'b1);
        push_column(top, mid, px);
      end else begin
        push_column(top, mid, px);
        if (ir >= 1) emit_pixel(1'b0);
      end
      ic++;
      if (ic >= wd) begin
        ic = 0;
        ir++;
        if (ir >= ht) pend_cnt = wd + 1;
      end
      in_col = ic;
      in_row = ir;
    end else begin
      // release phase: virtual row below the frame, item data unused
      if (ic == 0 || ic >= wd) begin
        emit_pixel(1'b1);
        if (ic == 0) begin
          top = line_mem[line_addr(ir, 0)];
          mid = line_mem[line_addr(ir + 1, 0)];
          push_column(top, mid, mid);
        end
      end else begin
        top = line_mem[line_addr(ir, ic)];
        mid = line_mem[line_addr(ir + 1, ic)];
        push_column(top, mid, mid);
        emit_pixel(1'b0);
      end
      in_col = ic + 1;
      pend_cnt--;
      if (pend_cnt == 0) clear_frame();
    end
  endfunction

  // input driver and output ready randomiser
  always @(negedge clk_i) begin
    px_item_t nxt;
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni) begin
      if (s_axis_tvalid && !in_fire) begin
        // hold until transfer
      end else if (pend_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pend_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.pixel;
        s_axis_tuser  <= nxt.action;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // transfer monitor and checker
  always @(posedge clk_i) begin
    smooth_res_t want;
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_fire) smooth_predict(s_axis_tuser, pix_t'(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (smooth_exp_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: filtered %0d last %0b",
                   $signed(m_axis_tdata), m_axis_tlast);
        mismatches++;
      end else begin
        want = smooth_exp_q.pop_front();
        if (want.filtered !== m_axis_tdata || want.frame_last !== m_axis_tlast) begin
          if (mismatches < 10)
            $display("mismatch: filtered exp %0d got %0d, last exp %0b got %0b",
                     want.filtered, $signed(m_axis_tdata), want.frame_last, m_axis_tlast);
          mismatches++;
        end
      end
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_item(logic action, pix_t px);
    px_item_t it;
    it.action = action;
    it.pixel = px;
    pend_items.push_back(it);
  endtask

  function automatic pix_t rand_pix();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return r[PIX_BITS-1:0];
    endcase
  endfunction

  task automatic wait_drained();
    while (pend_items.size() != 0 || s_axis_tvalid || smooth_exp_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(sfc_pkg::cfg_reg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i  <= 1'b1;
    cfg_idx_i <= idx;
    if (idx == sfc_pkg::CFG_FRAME_WIDTH) begin
      cfg_data_i <= CFG_DW'(val & 32'h7FF);
      width_reg = FW_W'(val);
    end else begin
      cfg_data_i <= CFG_DW'(val);
      height_reg = FH_W'(val);
    end
    clear_frame();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // cut: 0 whole frame, -1 random break point, >0 pixels sent before abandoning
  task automatic smooth_frame(int unsigned w_val, int unsigned h_val, int cut);
    int unsigned wd, ht, npx;
    settle();
    write_reg(sfc_pkg::CFG_FRAME_WIDTH, w_val);
    write_reg(sfc_pkg::CFG_FRAME_HEIGHT, h_val);
    wd = eff_width();
    ht = eff_height();
    npx = wd * ht;
    if (cut < 0) npx = $urandom_range(npx - 1, 1);
    else if (cut > 0) npx = cut;
    for (int unsigned k = 0; k < npx; k++) begin
      if ($urandom_range(29) == 0) add_item(ACT_DRAIN, rand_pix());
      add_item(ACT_PIXEL, rand_pix());
      if (k == npx / 2 && $urandom_range(3) == 0) wait_drained();
    end
    items_queued += npx;
    if (cut == 0) begin
      for (int unsigned k = 0; k <= wd; k++)
        add_item(($urandom_range(3) == 0) ? ACT_PIXEL : ACT_DRAIN, rand_pix());
      items_queued += wd + 1;
      if ($urandom_range(3) == 0) add_item(ACT_DRAIN, rand_pix());
    end
  endtask

  initial begin
    int unsigned wv, hv, target;
    for (int k = 0; k < 2 * MAX_W; k++) line_mem[k] = '0;
    clear_frame();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // smallest frame, field extremes, pixel acting as drain, idle drain
    settle();
    write_reg(sfc_pkg::CFG_FRAME_WIDTH, 0);
    write_reg(sfc_pkg::CFG_FRAME_HEIGHT, 1);
    add_item(ACT_PIXEL, 16'h7FFF);
    add_item(ACT_PIXEL, 16'h8000);
    add_item(ACT_PIXEL, 16'hFFFF);
    add_item(ACT_PIXEL, 16'h0000);
    add_item(ACT_DRAIN, 16'h0000);
    add_item(ACT_PIXEL, 16'd12345);
    add_item(ACT_DRAIN, 16'h0000);
    add_item(ACT_DRAIN, 16'hFFFF);
    // 3x3 checkerboard of extremes
    settle();
    write_reg(sfc_pkg::CFG_FRAME_WIDTH, 3);
    write_reg(sfc_pkg::CFG_FRAME_HEIGHT, 3);
    for (int k = 0; k < 9; k++) add_item(ACT_PIXEL, k[0] ? 16'h7FFF : 16'h8000);
    repeat (4) add_item(ACT_DRAIN, 16'h0000);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0: smooth_frame(5, 65535, 60);
        1: smooth_frame(2047, 40000, 1040);
        default: smooth_frame(64, 3, 0);
      endcase
      target = items_queued + 100;
      while (items_queued < target) begin
        case ($urandom_range(9))
          0: wv = $urandom_range(1);
          1: wv = $urandom_range(40, 13);
          default: wv = $urandom_range(12, 2);
        endcase
        case ($urandom_range(9))
          0: hv = $urandom_range(1);
          1: hv = $urandom_range(20, 7);
          default: hv = $urandom_range(6, 2);
        endcase
        smooth_frame(wv, hv, ($urandom_range(7) == 0) ? -1 : 0);
      end
    end

    settle();
    if (mismatches == 0 && smooth_exp_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/sfc_pkg.sv
hdl/sfc_ram.sv
hdl/sfc_ctrl.sv
hdl/sfc_win.sv
hdl/sfc_div.sv
hdl/clamped_3x3_smoothing_filter.sv
bench/tb_clamped_3x3_smoothing_filter.sv
